@@ sv/hamming_nearest_descriptor_match_defines.svh @@
// Assertion macros shared by the matcher's checker.
`ifndef HAMMING_NEAREST_DESCRIPTOR_MATCH_DEFINES_SVH
`define HAMMING_NEAREST_DESCRIPTOR_MATCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HNDM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HNDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/hndm_pkg.sv @@
// Types, sizes and helper functions for the Hamming descriptor matcher.
`default_nettype none

package hndm_pkg;

	localparam int TABLE_DEPTH      = 256;
	localparam int DESCRIPTOR_WORDS = 8;

	localparam int LANE_COUNT     = 4;
	localparam int LANE_W         = 64;
	localparam int WORD_W         = 32;
	localparam int DESC_W         = LANE_COUNT * LANE_W;
	localparam int CARRIED_WORDS  = DESC_W / WORD_W;
	localparam int COMPARED_WORDS = (DESCRIPTOR_WORDS < CARRIED_WORDS) ?
	                                DESCRIPTOR_WORDS : CARRIED_WORDS;

	localparam int SLOT_W  = 8;
	localparam int COUNT_W = 9;
	localparam int DIST_W  = 9;
	localparam int WPOP_W  = 6;
	localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] slot;
		logic [LANE_W-1:0] bits_3;
		logic [LANE_W-1:0] bits_2;
		logic [LANE_W-1:0] bits_1;
		logic [LANE_W-1:0] bits_0;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] query_index;
		logic [SLOT_W-1:0] best_entry;
		logic [DIST_W-1:0] match_distance;
		logic              no_match;
	} out_item_t;

	typedef enum logic {
		OP_LOAD,
		OP_QUERY
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [DESC_W-1:0] desc;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

	// SWAR popcount of one 32-bit word.
	function automatic logic [WPOP_W-1:0] word_popcount(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		a = v - ((v >> 1) & 32'h5555_5555);
		b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
		c = (b + (b >> 4)) & 32'h0F0F_0F0F;
		return WPOP_W'(c[7:0] + c[15:8] + c[23:16] + c[31:24]);
	endfunction

endpackage

`default_nettype wire

@@ sv/hndm_front.sv @@
// Front end: accepts items, classifies them and queues commands for the back end.
`default_nettype none

module hndm_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  hndm_pkg::in_item_t      item,
	output logic                    busy,
	input  wire                     pop,
	output hndm_pkg::queue_head_t   head
);
	import hndm_pkg::*;

	cmd_t              q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	cmd_t cmd;
	logic accept;
	logic keep;
	logic push;
	logic do_pop;

	assign busy   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign accept = start && !busy;

	// Drop loads aimed past the end of the table.
	always_comb begin
		cmd.op   = (item.kind == KIND_QUERY) ? OP_QUERY : OP_LOAD;
		cmd.slot = item.slot;
		cmd.desc = {item.bits_3, item.bits_2, item.bits_1, item.bits_0};
		keep     = (cmd.op == OP_QUERY) || (32'(item.slot) < TABLE_DEPTH);
	end

	assign push   = accept && keep;
	assign do_pop = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.cmd   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/hndm_back.sv @@
// Back end: reference table, distance pipeline and best-match tracking.
`default_nettype none

module hndm_back (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [hndm_pkg::COUNT_W-1:0]   cfg_wdata,
	input  hndm_pkg::queue_head_t         head,
	output logic                          pop,
	output logic                          done,
	output hndm_pkg::out_item_t           result
);
	import hndm_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] entry_count_q;
	logic [CNT_W-1:0]   limit_q;
	logic [CNT_W-1:0]   ctr_q;
	logic [DESC_W-1:0]  query_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [DIST_W-1:0]  best_dist_q;
	logic               done_q;
	out_item_t          result_q;

	logic [DESC_W-1:0]  mem [TABLE_DEPTH];

	logic [DESC_W-1:0]  rd_s1;
	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [WPOP_W-1:0]  pc_s2 [CARRIED_WORDS];
	logic               v_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [DIST_W-1:0]  dist_s3;
	logic               v_s3;
	logic [IDX_W-1:0]   idx_s3;

	logic               start_load;
	logic               start_query;
	logic               issue;
	logic               finish;
	logic [CNT_W-1:0]   limit;
	logic [DIST_W-1:0]  dist_sum;
	logic               better;

	assign start_load  = (state_q == ST_IDLE) && head.valid && (head.cmd.op == OP_LOAD);
	assign start_query = (state_q == ST_IDLE) && head.valid && (head.cmd.op == OP_QUERY);
	assign pop         = start_load || start_query;

	// Clamp the configured count to the table size.
	assign limit = (32'(entry_count_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
	                                                  : CNT_W'(entry_count_q);

	assign issue  = (state_q == ST_SCAN) && (ctr_q < limit_q);
	assign finish = (state_q == ST_SCAN) && !issue && !v_s1 && !v_s2 && !v_s3;
	assign better = v_s3 && (!found_q || (dist_s3 < best_dist_q));

	always_comb begin
		dist_sum = '0;
		for (int w = 0; w < CARRIED_WORDS; w++) begin
			dist_sum = dist_sum + DIST_W'(pc_s2[w]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	// One write port for loads, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (start_load) begin
			mem[IDX_W'(head.cmd.slot)] <= head.cmd.desc;
		end
		rd_s1 <= mem[ctr_q[IDX_W-1:0]];
	end

	// Distance pipeline payload.
	always_ff @(posedge clk) begin
		idx_s1 <= ctr_q[IDX_W-1:0];
		for (int w = 0; w < CARRIED_WORDS; w++) begin
			pc_s2[w] <= (w < COMPARED_WORDS) ?
			            word_popcount(rd_s1[w*WORD_W +: WORD_W] ^ query_q[w*WORD_W +: WORD_W]) :
			            '0;
		end
		idx_s2  <= idx_s1;
		dist_s3 <= dist_sum;
		idx_s3  <= idx_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= '0;
			ctr_q       <= '0;
			query_q     <= '0;
			slot_q      <= '0;
			found_q     <= 1'b0;
			best_idx_q  <= '0;
			best_dist_q <= '0;
			done_q      <= 1'b0;
			result_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start_query) begin
						query_q <= head.cmd.desc;
						slot_q  <= head.cmd.slot;
						limit_q <= limit;
						ctr_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						ctr_q <= ctr_q + 1'b1;
					end
					// Strict less-than keeps the earlier entry on ties.
					if (better) begin
						found_q     <= 1'b1;
						best_idx_q  <= idx_s3;
						best_dist_q <= dist_s3;
					end
					if (finish) begin
						done_q                  <= 1'b1;
						result_q.query_index    <= slot_q;
						result_q.best_entry     <= found_q ? SLOT_W'(best_idx_q) : '0;
						result_q.match_distance <= found_q ? best_dist_q : '0;
						result_q.no_match       <= !found_q;
						state_q                 <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

@@ sv/hamming_nearest_descriptor_match.sv @@
// Top level of the brute-force Hamming matcher for 256-bit descriptors.
// Each query scans min(entry_count, 256) entries through the single table read port, one
// entry a cycle; a new command is taken only once the previous one has finished, while the
// command queue holds up to two further items.
// Reset clears entry_count, the queue and the control state; the table is not cleared.
`default_nettype none

module hamming_nearest_descriptor_match (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  hndm_pkg::in_item_t           item,
	output logic                         busy,
	input  wire                          cfg_we,
	input  wire [hndm_pkg::COUNT_W-1:0]  cfg_wdata,
	output logic                         done,
	output hndm_pkg::out_item_t          result
);
	import hndm_pkg::*;

	queue_head_t head;
	logic        pop;

	hndm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.pop    (pop),
		.head   (head)
	);

	hndm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.pop       (pop),
		.done      (done),
		.result    (result)
	);

endmodule

`default_nettype wire

@@ sv/hndm_checker.sv @@
// Port-level checks for the matcher, bound to the top level.
`default_nettype none
`include "hamming_nearest_descriptor_match_defines.svh"

module hndm_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  done,
	input hndm_pkg::out_item_t  result
);
	import hndm_pkg::*;

	`HNDM_ASSERT_NOW(a_no_match_zero, clk, arst_n, done && result.no_match, (result.best_entry == '0) && (result.match_distance == '0), "no-match result carries nonzero entry or distance")
	`HNDM_ASSERT_NOW(a_dist_range, clk, arst_n, done, result.match_distance <= DIST_W'(COMPARED_WORDS * WORD_W), "distance exceeds compared bit count")
	`HNDM_ASSERT_NEXT(a_no_back_to_back, clk, arst_n, done, !done, "results strobed in consecutive cycles")

endmodule

bind hamming_nearest_descriptor_match hndm_checker u_hndm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.done   (done),
	.result (result)
);

`default_nettype wire

@@ tb/nearest_match_checker.sv @@
// Checker for the Hamming matcher: predicts each query's nearest entry and compares results.
`default_nettype none

module nearest_match_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire                           busy,
	input  hndm_pkg::in_item_t            item,
	input  wire                           cfg_we,
	input  wire [hndm_pkg::COUNT_W-1:0]   cfg_wdata,
	input  wire                           done,
	input  hndm_pkg::out_item_t           result,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import hndm_pkg::*;

	localparam logic [DESC_W-1:0] CMP_MASK = {DESC_W{1'b1}} >> (DESC_W - COMPARED_WORDS * WORD_W);

	logic [COUNT_W-1:0] entry_count = '0;
	logic [DESC_W-1:0]  ref_rows [TABLE_DEPTH];
	out_item_t          answers_q [$];
	int                 mismatches = 0;

	// Scan entries below the saturated count; a strict compare keeps the lower index on ties.
	function automatic out_item_t nearest_entry(input logic [SLOT_W-1:0] qidx,
			input logic [DESC_W-1:0] desc);
		out_item_t best;
		int        limit;
		int        diff_bits;
		logic      found;
		best = '0;
		best.query_index = qidx;
		found = 1'b0;
		limit = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
		for (int j = 0; j < limit; j++) begin
			diff_bits = $countones((desc ^ ref_rows[IDX_W'(j)]) & CMP_MASK);
			if (!found || diff_bits < int'(best.match_distance)) begin
				found = 1'b1;
				best.match_distance = DIST_W'(diff_bits);
				best.best_entry = SLOT_W'(j);
			end
		end
		best.no_match = !found;
		return best;
	endfunction

	function automatic int field_diff(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			entry_count = '0;
			answers_q.delete();
		end else begin
			if (cfg_we)
				entry_count = cfg_wdata;
			if (done) begin
				if (answers_q.size() == 0) begin
					$error("result for query %0d with no query outstanding", result.query_index);
					mismatches++;
				end else begin
					want = answers_q.pop_front();
					mismatches += field_diff("query_index", 16'(want.query_index),
							16'(result.query_index))
						+ field_diff("best_entry", 16'(want.best_entry),
							16'(result.best_entry))
						+ field_diff("best_distance", 16'(want.match_distance),
							16'(result.match_distance))
						+ field_diff("no_match", 16'(want.no_match), 16'(result.no_match));
				end
			end
			if (start && !busy) begin
				if (item.kind == OP_QUERY)
					answers_q = {answers_q, nearest_entry(item.slot,
						{item.bits_3, item.bits_2, item.bits_1, item.bits_0})};
				else
					ref_rows[item.slot] = {item.bits_3, item.bits_2, item.bits_1, item.bits_0};
			end
		end
		fail_count <= mismatches;
		pending <= answers_q.size();
	end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Top of the Hamming matcher testbench: reset, loads, queries, count settings and verdict.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hndm_pkg::*;

	localparam int DRAIN_CYCLES = TABLE_DEPTH + 10;
	localparam int PHASE_ITEMS  = 85;
	localparam int PHASES       = 8;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	in_item_t           item = '0;
	logic               cfg_we = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;
	logic               busy;
	logic               done;
	out_item_t          result;
	int                 fail_count;
	int                 pending;
	int                 idle_pct = 36;

	// Descriptors last loaded per slot, used to aim queries near known entries.
	logic [DESC_W-1:0]  shadow [TABLE_DEPTH];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	hamming_nearest_descriptor_match dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	nearest_match_checker match_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic logic [DESC_W-1:0] rand_desc();
		logic [DESC_W-1:0] d;
		int                pick;
		pick = $urandom_range(15);
		for (int w = 0; w < DESC_W / 32; w++)
			d[w*32 +: 32] = $urandom;
		if (pick == 0)
			d = '0;
		else if (pick == 1)
			d = '1;
		return d;
	endfunction

	function automatic logic [DESC_W-1:0] flip_bits(input logic [DESC_W-1:0] d, input int n);
		logic [DESC_W-1:0] r;
		r = d;
		for (int k = 0; k < n; k++)
			r[$urandom_range(DESC_W-1)] ^= 1'b1;
		return r;
	endfunction

	function automatic in_item_t make_item(input op_t op, input logic [SLOT_W-1:0] s,
			input logic [DESC_W-1:0] d);
		in_item_t it;
		it.kind = op;
		it.slot = s;
		{it.bits_3, it.bits_2, it.bits_1, it.bits_0} = d;
		return it;
	endfunction

	// Enter and leave at a falling edge; start stays high after the transfer.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_entry(input logic [SLOT_W-1:0] s, input logic [DESC_W-1:0] d);
		shadow[s] = d;
		send_item(make_item(OP_LOAD, s, d));
	endtask

	task automatic run_query(input logic [SLOT_W-1:0] s, input logic [DESC_W-1:0] d);
		send_item(make_item(OP_QUERY, s, d));
	endtask

	// Wait for every answer, then let any trailing load finish.
	task automatic settle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [DESC_W-1:0]  d;
		logic [COUNT_W-1:0] v;
		int                 span;
		int                 pick;
		int                 j;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table straight out of reset.
		run_query(8'hFF, '1);
		load_entry(8'd0, '0);
		load_entry(8'd1, '1);
		load_entry(8'd2, '0);
		load_entry(8'd3, {(DESC_W/4){4'hA}});
		load_entry(8'd255, rand_desc());
		settle();
		write_count(9'd4);
		run_query(8'd0, '0);
		run_query(8'd1, '1);
		run_query(8'd2, {(DESC_W/4){4'h5}});
		run_query(8'd3, {1'b1, {(DESC_W-1){1'b0}}});
		run_query(8'd4, {(DESC_W/4){4'hA}});
		run_query(8'h80, {{LANE_W{1'b1}}, {(DESC_W-LANE_W){1'b0}}});
		settle();
		write_count(9'd1);
		run_query(8'h55, rand_desc());
		settle();
		write_count(9'd0);
		run_query(8'hAA, rand_desc());

		// Fill the whole table; some rows repeat earlier ones to force ties.
		for (int s = 0; s < TABLE_DEPTH; s++) begin
			if (s > 0 && $urandom_range(9) == 0)
				d = shadow[$urandom_range(s-1)];
			else
				d = rand_desc();
			load_entry(SLOT_W'(s), d);
		end
		settle();
		write_count('1);
		for (int k = 0; k < 4; k++)
			run_query(SLOT_W'($urandom), flip_bits(shadow[$urandom_range(TABLE_DEPTH-1)], k));

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: v = COUNT_W'(TABLE_DEPTH);
				1: v = COUNT_W'($urandom_range(2, 16));
				2: v = 9'd1;
				3: v = COUNT_W'($urandom_range(TABLE_DEPTH + 1, (1 << COUNT_W) - 1));
				4: v = COUNT_W'($urandom_range(17, 64));
				5: v = COUNT_W'(TABLE_DEPTH - 1);
				6: v = COUNT_W'($urandom_range(2, 32));
				default: v = '0;
			endcase
			write_count(v);
			span = (v > TABLE_DEPTH) ? TABLE_DEPTH : int'(v);
			// One phase runs back to back with no gaps at all.
			idle_pct = (ph == 6) ? 0 : 36;
			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 40) begin
					if ($urandom_range(4) == 0)
						d = shadow[$urandom_range(TABLE_DEPTH-1)];
					else
						d = rand_desc();
					load_entry(SLOT_W'($urandom), d);
				end else begin
					j = (span > 0) ? $urandom_range(span-1) : $urandom_range(TABLE_DEPTH-1);
					pick = $urandom_range(99);
					if (pick < 30)
						d = shadow[j];
					else if (pick < 70)
						d = flip_bits(shadow[j], $urandom_range(1, 8));
					else if (pick < 80)
						d = ~shadow[j];
					else
						d = rand_desc();
					run_query(SLOT_W'($urandom), d);
				end
			end
		end
		settle();

		if (fail_count == 0 && pending == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#15ms;
		$display("tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
